/* rtl/rns_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and the saturating add for the radial neighbor select core.
// Depends on nothing; the core refers to it by scoped names.
package rns_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATOM_COUNT = 2'd1;

    // Fixed field widths.
    localparam int RADIUS_W = 32;
    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int POS_IN_W = 32;

    // Distance accumulator width; the sum of squares saturates here.
    localparam int DIST_W = 64;

    // Unsigned add that sticks at all ones on overflow.
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

endpackage

/* rtl/radial_neighbor_select_core.sv */
`timescale 1ns / 1ps
// Top level of the radial neighbor select core: position memory, pair sweep
// pipeline and result emitter. Depends on rns_pkg for constants and sat_add.
//
//  channel   signals                                         handshake
//  -------   ----------------------------------------------  ---------------------
//  command   start, busy, mode, atom_index, x/y/z_pos, marks  start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//  result    result_valid, selected_atom, none_selected, last one-cycle strobe
//
// A load item never raises busy; loads can follow each other every cycle.
// During a run item busy stays high while the pair sweep reads one candidate
// position a cycle from the single read port of the position memory, the
// distance pipeline drains, then the hit map is scanned one atom a cycle.
// Results come out one per cycle at most during the scan and cannot be stalled.
// Reset clears marks and hit map and sets radius to zero and atom count to 64;
// the position memory is not cleared and needs no clearing pass.
module radial_neighbor_select_core #(
    parameter int MAX_ATOMS   = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [rns_pkg::INDEX_W-1:0]         atom_index,
    input  logic signed [rns_pkg::POS_IN_W-1:0] x_pos,
    input  logic signed [rns_pkg::POS_IN_W-1:0] y_pos,
    input  logic signed [rns_pkg::POS_IN_W-1:0] z_pos,
    input  logic                                is_center,
    input  logic                                is_candidate,
    // Configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rns_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rns_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Result channel
    output logic                                result_valid,
    output logic [rns_pkg::INDEX_W-1:0]         selected_atom,
    output logic                                none_selected,
    output logic                                last
);

    localparam int IDX_W = $clog2(MAX_ATOMS);
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);
    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int POS_W = 3 * COORD_WIDTH;
    localparam logic [rns_pkg::COUNT_W-1:0] MAX_COUNT = rns_pkg::COUNT_W'(MAX_ATOMS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_INIT,
        ST_CTR_CHECK,
        ST_CTR_LATCH,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [rns_pkg::RADIUS_W-1:0] radius_reg;
    logic [rns_pkg::COUNT_W-1:0]  atom_count_reg;

    // Marks and hit map live in flip-flops so reset clears them at once.
    logic [MAX_ATOMS-1:0] center_mark_reg;
    logic [MAX_ATOMS-1:0] candidate_mark_reg;
    logic [MAX_ATOMS-1:0] hit_reg;

    // Loop counters.
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;

    // Pending result held back until the next hit or the end of the scan.
    logic             pend_valid_reg;
    logic [IDX_W-1:0] pend_idx_reg;

    // Result registers.
    logic                        result_valid_reg;
    logic [rns_pkg::INDEX_W-1:0] selected_atom_reg;
    logic                        none_selected_reg;
    logic                        last_reg;

    // Position memory and its read port.
    logic [POS_W-1:0] pos_mem [MAX_ATOMS];
    logic [POS_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_we;
    logic [IDX_W-1:0] load_addr;
    logic [POS_W-1:0] load_word;

    // Datapath registers.
    logic [COORD_WIDTH-1:0]    ctr_x_reg, ctr_y_reg, ctr_z_reg;
    logic [rns_pkg::DIST_W-1:0] r2_reg;
    logic                      v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]          j0_reg, j1_reg, j2_reg, j3_reg;
    logic [COORD_WIDTH-1:0]    mag_reg [3];
    logic [SQ_W-1:0]           sq_reg [3];
    logic [rns_pkg::DIST_W-1:0] sxy_reg;
    logic [rns_pkg::DIST_W-1:0] sz_reg;

    logic                      accept;
    logic [CNT_W-1:0]          n_atoms;
    logic [IDX_W-1:0]          i_idx, j_idx, k_idx;
    logic                      pipe_busy;
    logic [COORD_WIDTH-1:0]    mag [3];
    logic [COORD_WIDTH-1:0]    cand_coord [3];
    logic [COORD_WIDTH-1:0]    ctr_coord [3];
    logic signed [COORD_WIDTH:0] diff [3];
    logic [rns_pkg::DIST_W-1:0] dist_total;
    logic                      pair_hit;

    // Handshake and loop bounds.
    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign n_atoms   = (atom_count_reg > MAX_COUNT) ? CNT_W'(MAX_ATOMS)
                                                    : CNT_W'(atom_count_reg);
    assign i_idx     = i_reg[IDX_W-1:0];
    assign j_idx     = j_reg[IDX_W-1:0];
    assign k_idx     = k_reg[IDX_W-1:0];
    assign pipe_busy = v0_reg || v1_reg || v2_reg || v3_reg;

    // Load path into the position memory.
    assign load_we   = accept && !mode && ({1'b0, atom_index} < MAX_COUNT);
    assign load_addr = atom_index[IDX_W-1:0];
    assign load_word = {z_pos[COORD_WIDTH-1:0], y_pos[COORD_WIDTH-1:0],
                        x_pos[COORD_WIDTH-1:0]};

    // Read address: each atom index while seeking the next center, then every atom in turn.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = j_idx;
        case (state_reg)
            ST_CTR_CHECK:
            begin
                rd_en   = (i_reg < n_atoms);
                rd_addr = i_idx;
            end
            ST_SWEEP:
            begin
                rd_en   = 1'b1;
                rd_addr = j_idx;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = j_idx;
            end
        endcase
    end

    // Position memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            pos_mem[load_addr] <= load_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= pos_mem[rd_addr];
        end
    end

    // Absolute coordinate differences between the candidate and the center.
    always_comb
    begin
        cand_coord[0] = rd_data_reg[COORD_WIDTH-1:0];
        cand_coord[1] = rd_data_reg[2*COORD_WIDTH-1:COORD_WIDTH];
        cand_coord[2] = rd_data_reg[3*COORD_WIDTH-1:2*COORD_WIDTH];
        ctr_coord[0]  = ctr_x_reg;
        ctr_coord[1]  = ctr_y_reg;
        ctr_coord[2]  = ctr_z_reg;
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = $signed({cand_coord[a][COORD_WIDTH-1], cand_coord[a]})
                    - $signed({ctr_coord[a][COORD_WIDTH-1], ctr_coord[a]});
            mag[a]  = diff[a][COORD_WIDTH] ? COORD_WIDTH'(-diff[a])
                                           : diff[a][COORD_WIDTH-1:0];
        end
    end

    // Final saturating add and the strict compare against radius squared.
    assign dist_total = rns_pkg::sat_add(sxy_reg, sz_reg);
    assign pair_hit   = v3_reg && (dist_total < r2_reg);

    // Distance pipeline payload: difference, square, partial sum.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN_INIT)
        begin
            r2_reg <= rns_pkg::DIST_W'(radius_reg) * rns_pkg::DIST_W'(radius_reg);
        end
        if (state_reg == ST_CTR_LATCH)
        begin
            ctr_x_reg <= rd_data_reg[COORD_WIDTH-1:0];
            ctr_y_reg <= rd_data_reg[2*COORD_WIDTH-1:COORD_WIDTH];
            ctr_z_reg <= rd_data_reg[3*COORD_WIDTH-1:2*COORD_WIDTH];
        end
        j0_reg <= j_idx;
        j1_reg <= j0_reg;
        j2_reg <= j1_reg;
        j3_reg <= j2_reg;
        for (int a = 0; a < 3; a++)
        begin
            mag_reg[a] <= mag[a];
            sq_reg[a]  <= SQ_W'(mag_reg[a]) * SQ_W'(mag_reg[a]);
        end
        sxy_reg <= rns_pkg::sat_add(rns_pkg::DIST_W'(sq_reg[0]),
                                    rns_pkg::DIST_W'(sq_reg[1]));
        sz_reg  <= rns_pkg::DIST_W'(sq_reg[2]);
    end

    // Pipeline valid bits; a pair enters only for a marked candidate other than the center.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= (state_reg == ST_SWEEP) && candidate_mark_reg[j_idx] && (j_idx != i_idx);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Sequencer, configuration, marks, hit map and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            radius_reg         <= '0;
            atom_count_reg     <= rns_pkg::COUNT_W'(64);
            center_mark_reg    <= '0;
            candidate_mark_reg <= '0;
            hit_reg            <= '0;
            i_reg              <= '0;
            j_reg              <= '0;
            k_reg              <= '0;
            pend_valid_reg     <= 1'b0;
            pend_idx_reg       <= '0;
            result_valid_reg   <= 1'b0;
            selected_atom_reg  <= '0;
            none_selected_reg  <= 1'b0;
            last_reg           <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;

            // Configuration writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rns_pkg::CFG_RADIUS:     radius_reg     <= cfg_data[rns_pkg::RADIUS_W-1:0];
                    rns_pkg::CFG_ATOM_COUNT: atom_count_reg <= cfg_data[rns_pkg::COUNT_W-1:0];
                    default:                 ;
                endcase
            end

            // A hit from the pipeline marks its candidate.
            if (pair_hit)
            begin
                hit_reg[j3_reg] <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (load_we)
                    begin
                        center_mark_reg[load_addr]    <= is_center;
                        candidate_mark_reg[load_addr] <= is_candidate;
                    end
                    if (accept && mode)
                    begin
                        state_reg <= ST_RUN_INIT;
                    end
                end
                ST_RUN_INIT:
                begin
                    hit_reg   <= '0;
                    i_reg     <= '0;
                    state_reg <= ST_CTR_CHECK;
                end
                ST_CTR_CHECK:
                begin
                    if (i_reg >= n_atoms)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else if (!center_mark_reg[i_idx])
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_CTR_LATCH;
                    end
                end
                ST_CTR_LATCH:
                begin
                    j_reg     <= '0;
                    state_reg <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (j_reg + 1'b1 >= n_atoms)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_CTR_CHECK;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        k_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (k_reg >= n_atoms)
                    begin
                        // End of scan: flush the held hit, or report an empty run.
                        result_valid_reg  <= 1'b1;
                        last_reg          <= 1'b1;
                        none_selected_reg <= !pend_valid_reg;
                        selected_atom_reg <= pend_valid_reg ? rns_pkg::INDEX_W'(pend_idx_reg)
                                                            : '0;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        if (hit_reg[k_idx])
                        begin
                            if (pend_valid_reg)
                            begin
                                result_valid_reg  <= 1'b1;
                                last_reg          <= 1'b0;
                                none_selected_reg <= 1'b0;
                                selected_atom_reg <= rns_pkg::INDEX_W'(pend_idx_reg);
                            end
                            pend_valid_reg <= 1'b1;
                            pend_idx_reg   <= k_idx;
                        end
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign selected_atom = selected_atom_reg;
    assign none_selected = none_selected_reg;
    assign last          = last_reg;

    // The hit map is complete before the scan starts.
    a_emit_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !pipe_busy)
        else $error("distance pipeline still busy during result scan");

    // An empty run is always the final result.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && none_selected) |-> last)
        else $error("empty result without last");

    // Results only follow a cycle of the result scan.
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result outside the result scan");

    // After the final result the core is ready for the next item.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("core still busy after the final result");

    // The pipeline never carries pairs while idle.
    a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("pair in flight while idle");

endmodule
